>>> rtl/core/pfr_pkg.sv
// Shared types and constants for the packet framer ring FIFO.
package pfr_pkg;

    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [7:0] SYNC_RESET = 8'hAA;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC = 1'd1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_SUB    = 3'd1,
        STAT_NO_SPACE   = 3'd2,
        STAT_BUSY       = 3'd3,
        STAT_EMPTY      = 3'd4,
        STAT_NO_PACKET  = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HDR  = 5'b00010,
        ST_CSUM = 5'b00100,
        ST_DONE = 5'b01000,
        ST_READ = 5'b10000
    } state_t;

endpackage

>>> rtl/core/pfr_ring_mem.sv
// Byte-wide ring storage: one write port and one registered read port.
module pfr_ring_mem #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] ring_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/pfr_ctrl.sv
// Framer control: packet state, ring pointers, header sequencing and result register.
module pfr_ctrl #(
    parameter int unsigned RING_BYTES = 65536,
    parameter int unsigned AW         = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [4:0]                        src_id,
    input  logic [15:0]                       data_len,
    input  logic [7:0]                        payload_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pfr_pkg::status_t                  status,
    output logic [7:0]                        read_byte,
    output logic [15:0]                       fill_level,
    input  logic                              cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output logic [7:0]                        mem_wr_data,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_rd_addr,
    input  logic [7:0]                        mem_rd_data
);

    import pfr_pkg::*;

    localparam int unsigned CW = $clog2(RING_BYTES + 1);
    localparam int unsigned FW = (CW > 16) ? CW : 16;
    localparam int unsigned NW = (CW > 17) ? CW : 17;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    function automatic logic [CW-1:0] fill_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
        logic [CW-1:0] f;
        if (w >= r)
        begin
            f = CW'(w) - CW'(r);
        end
        else
        begin
            f = CW'(RING_BYTES) - CW'(r) + CW'(w);
        end
        return f;
    endfunction

    state_t        state_reg,  state_next;
    logic [AW-1:0] wp_reg,     wp_next;
    logic [AW-1:0] rp_reg,     rp_next;
    logic          open_reg,   open_next;
    logic          disc_reg,   disc_next;
    logic          drop_reg,   drop_next;
    logic [15:0]   left_reg,   left_next;
    logic [7:0]    xor_reg,    xor_next;
    logic [4:0]    id_reg,     id_next;
    logic [1:0]    hcnt_reg,   hcnt_next;
    logic [31:0]   mask_reg;
    logic [7:0]    sync_reg;
    logic          ovalid_reg, ovalid_next;
    status_t       status_reg, status_next;
    logic [7:0]    rbyte_reg,  rbyte_next;
    logic [15:0]   fill_reg,   fill_next;

    logic          out_free;
    logic          accept;
    logic [CW-1:0] fill_cur;
    logic [CW-1:0] room;
    logic [16:0]   need;
    logic          subscribed;
    logic          no_space;
    logic [7:0]    hdr_byte;
    logic          load;
    status_t       ld_status;
    logic [7:0]    ld_rbyte;
    logic [FW-1:0] fill_after;
    status_t       drop_status;

    assign out_free   = !ovalid_reg || !out_stall;
    assign in_stall   = !((state_reg == ST_IDLE) && out_free);
    assign accept     = in_valid && !in_stall;
    assign fill_cur   = fill_of(wp_reg, rp_reg);
    assign room       = CW'(RING_BYTES - 1) - fill_cur;
    assign need       = {1'b0, data_len} + 17'(HDR_BYTES + 1);
    assign subscribed = mask_reg[src_id];
    assign no_space   = NW'(room) < NW'(need);
    assign drop_status = drop_reg ? STAT_NO_SPACE : STAT_NOT_SUB;

    always_comb
    begin
        case (hcnt_reg)
            2'd1:    hdr_byte = 8'(id_reg);
            2'd2:    hdr_byte = left_reg[7:0];
            default: hdr_byte = left_reg[15:8];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        open_next   = open_reg;
        disc_next   = disc_reg;
        drop_next   = drop_reg;
        left_next   = left_reg;
        xor_next    = xor_reg;
        id_next     = id_reg;
        hcnt_next   = hcnt_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wp_reg;
        mem_wr_data = 8'd0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rp_reg;
        load        = 1'b0;
        ld_status   = STAT_OK;
        ld_rbyte    = 8'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_START:
                        begin
                            if (open_reg || disc_reg)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_BUSY;
                            end
                            else if (!subscribed || no_space)
                            begin
                                load      = 1'b1;
                                ld_status = subscribed ? STAT_NO_SPACE : STAT_NOT_SUB;
                                drop_next = subscribed;
                                if (data_len != 16'd0)
                                begin
                                    disc_next = 1'b1;
                                    left_next = data_len;
                                end
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = sync_reg;
                                wp_next     = next_pos(wp_reg);
                                xor_next    = sync_reg;
                                id_next     = src_id;
                                left_next   = data_len;
                                open_next   = (data_len != 16'd0);
                                hcnt_next   = 2'd1;
                                state_next  = ST_HDR;
                            end
                        end
                        OP_PAYLOAD:
                        begin
                            if (open_reg)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = payload_byte;
                                wp_next     = next_pos(wp_reg);
                                xor_next    = xor_reg ^ payload_byte;
                                left_next   = left_reg - 16'd1;
                                if (left_reg == 16'd1)
                                begin
                                    open_next  = 1'b0;
                                    state_next = ST_CSUM;
                                end
                                else
                                begin
                                    load = 1'b1;
                                end
                            end
                            else if (disc_reg)
                            begin
                                load      = 1'b1;
                                ld_status = drop_status;
                                left_next = left_reg - 16'd1;
                                if (left_reg == 16'd1)
                                begin
                                    disc_next = 1'b0;
                                end
                            end
                            else
                            begin
                                load      = 1'b1;
                                ld_status = STAT_NO_PACKET;
                            end
                        end
                        OP_READ:
                        begin
                            if (fill_cur == '0)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                rp_next    = next_pos(rp_reg);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_HDR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = hdr_byte;
                wp_next     = next_pos(wp_reg);
                xor_next    = xor_reg ^ hdr_byte;
                hcnt_next   = hcnt_reg + 2'd1;
                if (hcnt_reg == 2'd3)
                begin
                    state_next = (left_reg == 16'd0) ? ST_CSUM : ST_DONE;
                end
            end
            ST_CSUM:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = xor_reg;
                wp_next     = next_pos(wp_reg);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_rbyte   = mem_rd_data;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign fill_after = FW'(fill_of(wp_next, rp_next));

    always_comb
    begin
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        rbyte_next  = rbyte_reg;
        fill_next   = fill_reg;
        if (load)
        begin
            ovalid_next = 1'b1;
            status_next = ld_status;
            rbyte_next  = ld_rbyte;
            fill_next   = fill_after[15:0];
        end
        else if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            rp_reg     <= '0;
            open_reg   <= 1'b0;
            disc_reg   <= 1'b0;
            drop_reg   <= 1'b0;
            left_reg   <= 16'd0;
            xor_reg    <= 8'd0;
            ovalid_reg <= 1'b0;
            mask_reg   <= 32'd0;
            sync_reg   <= SYNC_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            open_reg   <= open_next;
            disc_reg   <= disc_next;
            drop_reg   <= drop_next;
            left_reg   <= left_next;
            xor_reg    <= xor_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MASK: mask_reg <= cfg_data;
                    REG_SYNC: sync_reg <= cfg_data[7:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        hcnt_reg   <= hcnt_next;
        status_reg <= status_next;
        rbyte_reg  <= rbyte_next;
        fill_reg   <= fill_next;
    end

    assign out_valid  = ovalid_reg;
    assign status     = status_reg;
    assign read_byte  = rbyte_reg;
    assign fill_level = fill_reg;

endmodule

>>> rtl/core/packet_framer_ring_fifo_unit.sv
// Top level of the packet framer with its byte ring FIFO.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_stall    opcode, src_id, data_len, payload_byte
//   out      out_valid/out_stall  status, read_byte, fill_level
//   cfg      cfg_wr_en            cfg_index, cfg_data
//
// A payload byte, a dropped or refused start, a stray byte and an empty read end in idle.
// A read waits on the registered ring read; the last payload byte adds the checksum; an
// accepted start writes sync, header and (if empty) checksum: one write port, a byte a cycle.
// Reset clears pointers and packet state; ring contents are left as they are.
// A result waits in the output register while out_stall is high; input is stalled
// until that register can take the next result.
module packet_framer_ring_fifo_unit #(
    parameter int unsigned RING_BYTES = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [4:0]                    src_id,
    input  logic [15:0]                   data_len,
    input  logic [7:0]                    payload_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pfr_pkg::status_t              status,
    output logic [7:0]                    read_byte,
    output logic [15:0]                   fill_level,
    input  logic                          cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    import pfr_pkg::*;

    localparam int unsigned AW = $clog2(RING_BYTES);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    pfr_ctrl #(
        .RING_BYTES (RING_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .src_id       (src_id),
        .data_len     (data_len),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .read_byte    (read_byte),
        .fill_level   (fill_level),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    pfr_ring_mem #(
        .DEPTH (RING_BYTES),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
